// File: hdl/air_quality_zone_voter_unit_macros.svh
// Assertion macros shared by the air quality zone voter modules.
`ifndef AIR_QUALITY_ZONE_VOTER_UNIT_MACROS_SVH
`define AIR_QUALITY_ZONE_VOTER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define AQZV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define AQZV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: hdl/aqzv_pkg.sv
// Types, codes and constants of the air quality zone voter.
package aqzv_pkg;

   localparam int unsigned READING_W = 16;
   localparam int unsigned CNT_W     = 8;
   localparam int unsigned CSR_IDX_W = 4;

   // Votes a zone's counter must reach before it reports its color (1 to 255).
   localparam int unsigned VOTES = 3;
   localparam logic [CNT_W-1:0] VOTE_LIMIT = CNT_W'(VOTES);
   localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

   typedef logic [1:0] color_type;
   localparam color_type COLOR_NONE   = 2'd0;
   localparam color_type COLOR_GREEN  = 2'd1;
   localparam color_type COLOR_ORANGE = 2'd2;
   localparam color_type COLOR_RED    = 2'd3;

   typedef logic [1:0] buzz_type;
   localparam buzz_type BUZZ_NONE  = 2'd0;
   localparam buzz_type BUZZ_START = 2'd1;
   localparam buzz_type BUZZ_STOP  = 2'd2;

   localparam logic CMD_GAS = 1'b0;
   localparam logic CMD_PM  = 1'b1;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_CO2_WARN         = 4'd0;
   localparam csr_idx_type REG_CO2_DANGER       = 4'd1;
   localparam csr_idx_type REG_TVOC_WARN        = 4'd2;
   localparam csr_idx_type REG_TVOC_DANGER      = 4'd3;
   localparam csr_idx_type REG_FINE_PM_WARN     = 4'd4;
   localparam csr_idx_type REG_FINE_PM_DANGER   = 4'd5;
   localparam csr_idx_type REG_COARSE_PM_WARN   = 4'd6;
   localparam csr_idx_type REG_COARSE_PM_DANGER = 4'd7;

   typedef logic [READING_W-1:0] reading_type;

   typedef struct packed {
      reading_type warn;
      reading_type danger;
   } zone_level_type;

   typedef struct packed {
      zone_level_type co2;
      zone_level_type tvoc;
      zone_level_type fine_pm;
      zone_level_type coarse_pm;
   } level_set_type;

endpackage

// File: hdl/aqzv_csr.sv
// Level registers of the air quality zone voter, written over the csr channel.
module aqzv_csr
   import aqzv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_idx_type   csr_index,
   input  reading_type   csr_data,
   output level_set_type levels
);

   level_set_type levels_ff;
   level_set_type levels_in;

   assign csr_ready = 1'b1;
   assign levels    = levels_ff;

   always_comb begin
      levels_in = levels_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CO2_WARN:         levels_in.co2.warn         = csr_data;
            REG_CO2_DANGER:       levels_in.co2.danger       = csr_data;
            REG_TVOC_WARN:        levels_in.tvoc.warn        = csr_data;
            REG_TVOC_DANGER:      levels_in.tvoc.danger      = csr_data;
            REG_FINE_PM_WARN:     levels_in.fine_pm.warn     = csr_data;
            REG_FINE_PM_DANGER:   levels_in.fine_pm.danger   = csr_data;
            REG_COARSE_PM_WARN:   levels_in.coarse_pm.warn   = csr_data;
            REG_COARSE_PM_DANGER: levels_in.coarse_pm.danger = csr_data;
            default:              levels_in = levels_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= '0;
      end else begin
         levels_ff <= levels_in;
      end
   end

endmodule

// File: hdl/aqzv_channel.sv
// Zone classifier and danger/warning/normal vote counters of one channel.
`include "air_quality_zone_voter_unit_macros.svh"
module aqzv_channel
   import aqzv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           sample_en,
   input  reading_type    reading,
   input  zone_level_type level,
   output color_type      color
);

   logic [CNT_W-1:0] danger_ff, warn_ff, normal_ff;
   logic [CNT_W-1:0] danger_in, warn_in, normal_in;
   logic [CNT_W-1:0] mine, mine_inc;
   logic             in_danger, in_warn, report;
   color_type        zone_color;

   function automatic logic [CNT_W-1:0] dec_floor(input logic [CNT_W-1:0] v);
      return (v != '0) ? v - CNT_W'(1) : '0;
   endfunction

   always_comb begin
      in_danger = reading >= level.danger;
      in_warn   = !in_danger && (reading >= level.warn);
      if (in_danger) begin
         mine       = danger_ff;
         zone_color = COLOR_RED;
      end else if (in_warn) begin
         mine       = warn_ff;
         zone_color = COLOR_ORANGE;
      end else begin
         mine       = normal_ff;
         zone_color = COLOR_GREEN;
      end
      mine_inc = (mine == CNT_MAX) ? mine : mine + CNT_W'(1);
      report   = mine_inc >= VOTE_LIMIT;
      color    = report ? zone_color : COLOR_NONE;

      // bump the zone's counter, clear it on a report; decay the other two
      danger_in = in_danger ? (report ? '0 : mine_inc) : dec_floor(danger_ff);
      warn_in   = in_warn ? (report ? '0 : mine_inc) : dec_floor(warn_ff);
      normal_in = (!in_danger && !in_warn) ? (report ? '0 : mine_inc)
                                           : dec_floor(normal_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         danger_ff <= '0;
         warn_ff   <= '0;
         normal_ff <= '0;
      end else if (sample_en) begin
         danger_ff <= danger_in;
         warn_ff   <= warn_in;
         normal_ff <= normal_in;
      end
   end

   `AQZV_ASSERT_NOW(a_counts_below_limit, clock, reset, 1'b1,
      (danger_ff < VOTE_LIMIT) && (warn_ff < VOTE_LIMIT) && (normal_ff < VOTE_LIMIT))
   `AQZV_ASSERT_NEXT(a_danger_report_clears, clock, reset, sample_en && report && in_danger,
      danger_ff == '0)
   `AQZV_ASSERT_NEXT(a_silent_vote_counts, clock, reset, sample_en && !report,
      (danger_ff | warn_ff | normal_ff) != '0)

endmodule

// File: hdl/air_quality_zone_voter_unit.sv
// Air quality zone voter: per-channel zone votes, LED colors and buzzer control.
//
// Usage:
//   req_* carries one measurement round: command selects a gas round (CO2,
//   TVOC) or a particulate round (PM1, PM2.5, PM10). The item is taken at a
//   clock edge where req_valid is high and req_stall is low.
//   rsp_* returns one result per round: three LED color updates and the last
//   buzzer command of the round, taken where rsp_valid is high and rsp_stall
//   is low.
//   csr_* writes the eight 16-bit zone levels by index; csr_ready is always
//   high and writes to indexes above seven are dropped. Write levels only
//   while no round is in flight.
// Timing:
//   A round lands in an input register, is voted there and moves on to the
//   result register that drives rsp_*. One round is taken every cycle while
//   rsp_stall does not hold the result; the rate is set by the single counter
//   update per channel between the input and result registers.
// Reset clears the levels and all vote counters and arms the buzzer. While
//   rsp_stall is high the result holds, one more round waits in the input
//   register, and req_stall rises once that register is full.
`include "air_quality_zone_voter_unit_macros.svh"
module air_quality_zone_voter_unit
   import aqzv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  reading_type req_co2_reading,
   input  reading_type req_tvoc_reading,
   input  reading_type req_pm1_reading,
   input  reading_type req_pm25_reading,
   input  reading_type req_pm10_reading,
   input  logic        req_sound_enabled,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output color_type   rsp_co2_color,
   output color_type   rsp_tvoc_color,
   output color_type   rsp_pm_color,
   output buzz_type    rsp_buzzer_action,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  reading_type csr_data
);

   typedef struct packed {
      logic     armed;
      buzz_type action;
   } buzz_state_type;

   level_set_type  levels;

   logic           a_valid_ff, a_valid_in;
   logic           cmd_ff, sound_ff;
   reading_type    co2_ff, tvoc_ff, pm1_ff, pm25_ff, pm10_ff;
   logic           b_valid_ff, b_valid_in;
   color_type      co2_color_ff, tvoc_color_ff, pm_color_ff;
   buzz_type       action_ff;
   logic           armed_ff;

   logic           accept, b_open, advance, gas_en, pm_en;
   color_type      co2_c, tvoc_c, pm1_c, pm25_c, pm10_c;
   color_type      co2_out, tvoc_out, pm_out, pm_max;
   buzz_state_type buzz_mid, buzz_end;

   // Apply one reported color to the buzzer; keep the last command issued.
   function automatic buzz_state_type buzz_step(input color_type c, input logic snd,
                                                input buzz_state_type cur);
      buzz_state_type nxt;
      nxt = cur;
      if (c != COLOR_NONE) begin
         if (c == COLOR_RED && snd) begin
            if (cur.armed) begin
               nxt.armed  = 1'b0;
               nxt.action = BUZZ_START;
            end
         end else begin
            nxt.armed  = 1'b1;
            nxt.action = BUZZ_STOP;
         end
      end
      return nxt;
   endfunction

   aqzv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .levels    (levels)
   );

   assign b_open    = !b_valid_ff || !rsp_stall;
   assign advance   = a_valid_ff && b_open;
   assign req_stall = a_valid_ff && !b_open;
   assign accept    = req_valid && !req_stall;
   assign gas_en    = advance && (cmd_ff == CMD_GAS);
   assign pm_en     = advance && (cmd_ff == CMD_PM);

   aqzv_channel u_ch_co2 (
      .clock (clock), .reset (reset), .sample_en (gas_en),
      .reading (co2_ff), .level (levels.co2), .color (co2_c)
   );
   aqzv_channel u_ch_tvoc (
      .clock (clock), .reset (reset), .sample_en (gas_en),
      .reading (tvoc_ff), .level (levels.tvoc), .color (tvoc_c)
   );
   aqzv_channel u_ch_pm1 (
      .clock (clock), .reset (reset), .sample_en (pm_en),
      .reading (pm1_ff), .level (levels.fine_pm), .color (pm1_c)
   );
   aqzv_channel u_ch_pm25 (
      .clock (clock), .reset (reset), .sample_en (pm_en),
      .reading (pm25_ff), .level (levels.fine_pm), .color (pm25_c)
   );
   aqzv_channel u_ch_pm10 (
      .clock (clock), .reset (reset), .sample_en (pm_en),
      .reading (pm10_ff), .level (levels.coarse_pm), .color (pm10_c)
   );

   always_comb begin
      // color codes rise with priority, so the combined color is the largest
      pm_max   = (pm1_c > pm25_c) ? pm1_c : pm25_c;
      pm_max   = (pm10_c > pm_max) ? pm10_c : pm_max;
      co2_out  = (cmd_ff == CMD_GAS) ? co2_c : COLOR_NONE;
      tvoc_out = (cmd_ff == CMD_GAS) ? tvoc_c : COLOR_NONE;
      pm_out   = (cmd_ff == CMD_PM) ? pm_max : COLOR_NONE;
      buzz_mid = buzz_step((cmd_ff == CMD_GAS) ? co2_out : pm_out, sound_ff,
                           '{armed: armed_ff, action: BUZZ_NONE});
      buzz_end = buzz_step(tvoc_out, sound_ff, buzz_mid);
   end

   assign a_valid_in = accept || (a_valid_ff && !b_open);
   assign b_valid_in = advance || (b_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         armed_ff   <= 1'b1;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         if (advance) begin
            armed_ff <= buzz_end.armed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         co2_ff   <= req_co2_reading;
         tvoc_ff  <= req_tvoc_reading;
         pm1_ff   <= req_pm1_reading;
         pm25_ff  <= req_pm25_reading;
         pm10_ff  <= req_pm10_reading;
         sound_ff <= req_sound_enabled;
      end
      if (advance) begin
         co2_color_ff  <= co2_out;
         tvoc_color_ff <= tvoc_out;
         pm_color_ff   <= pm_out;
         action_ff     <= buzz_end.action;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_co2_color     = co2_color_ff;
   assign rsp_tvoc_color    = tvoc_color_ff;
   assign rsp_pm_color      = pm_color_ff;
   assign rsp_buzzer_action = action_ff;

   `AQZV_ASSERT_NOW(a_round_kind_exclusive, clock, reset,
      rsp_valid && (rsp_pm_color != COLOR_NONE),
      (rsp_co2_color == COLOR_NONE) && (rsp_tvoc_color == COLOR_NONE))
   `AQZV_ASSERT_NOW(a_start_needs_red, clock, reset,
      rsp_valid && (rsp_buzzer_action == BUZZ_START),
      (rsp_co2_color == COLOR_RED) || (rsp_tvoc_color == COLOR_RED) ||
      (rsp_pm_color == COLOR_RED))
   `AQZV_ASSERT_NEXT(a_stop_rearms, clock, reset,
      advance && (buzz_end.action == BUZZ_STOP) && (tvoc_out != COLOR_RED ||
      !sound_ff), armed_ff)
   `AQZV_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      a_valid_ff && b_valid_ff && rsp_stall)

endmodule

// File: sim/tb_air_quality_zone_voter_unit.sv
// Self-checking testbench for the air quality zone voter: random rounds, level sets, flow control.
module tb_air_quality_zone_voter_unit;
   import aqzv_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int ROUNDS_PER_SET = 360;
   localparam int LONG_HOLD_AT = 600;
   localparam int LONG_HOLD    = 80;

   // channel slots of the vote tallies
   localparam int CH_CO2  = 0;
   localparam int CH_TVOC = 1;
   localparam int CH_PM1  = 2;
   localparam int CH_PM25 = 3;
   localparam int CH_PM10 = 4;

   localparam int ZONE_NORMAL = 0;
   localparam int ZONE_WARN   = 1;
   localparam int ZONE_DANGER = 2;

   // level sets used by the random phases
   localparam int LV_TYPICAL = 0;
   localparam int LV_CROSSED = 1;
   localparam int LV_WIDE    = 2;
   localparam int LV_TOP     = 3;
   localparam int LV_RANDOM  = 4;

   typedef struct {
      logic        cmd;
      reading_type co2;
      reading_type tvoc;
      reading_type pm1;
      reading_type pm25;
      reading_type pm10;
      logic        snd;
      bit          drain_first;
   } meas_round_type;

   typedef struct packed {
      color_type co2;
      color_type tvoc;
      color_type pm;
      buzz_type  buzz;
   } led_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_GAS;
   reading_type req_co2_reading = '0;
   reading_type req_tvoc_reading = '0;
   reading_type req_pm1_reading = '0;
   reading_type req_pm25_reading = '0;
   reading_type req_pm10_reading = '0;
   logic        req_sound_enabled = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   color_type   rsp_co2_color;
   color_type   rsp_tvoc_color;
   color_type   rsp_pm_color;
   buzz_type    rsp_buzzer_action;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = '0;
   reading_type csr_data = '0;

   air_quality_zone_voter_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_co2_reading   (req_co2_reading),
      .req_tvoc_reading  (req_tvoc_reading),
      .req_pm1_reading   (req_pm1_reading),
      .req_pm25_reading  (req_pm25_reading),
      .req_pm10_reading  (req_pm10_reading),
      .req_sound_enabled (req_sound_enabled),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_co2_color     (rsp_co2_color),
      .rsp_tvoc_color    (rsp_tvoc_color),
      .rsp_pm_color      (rsp_pm_color),
      .rsp_buzzer_action (rsp_buzzer_action),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: levels, vote tallies and buzzer arming
   level_set_type    zone_levels = '0;
   logic [CNT_W-1:0] zone_tally [5][3] = '{default: '0};
   logic             alarm_armed = 1'b1;

   meas_round_type pending_rounds [$];
   led_report_type expected_reports [$];
   meas_round_type shown_round;

   int  run_zone [5] = '{default: 0};
   int  run_left [5] = '{default: 0};
   int  gap_left = 0;
   int  stall_left = 0;
   int  accepted_rounds = 0;
   int  gas_rounds = 0;
   int  pm_rounds = 0;
   int  level_sets = 0;
   int  mismatch_count = 0;
   int  red_seen = 0;
   int  orange_seen = 0;
   int  green_seen = 0;
   int  starts_seen = 0;
   int  stops_seen = 0;
   int  cycle_count = 0;
   int  quiet_cycles = 0;
   bit  no_idle = 1'b0;
   bit  long_hold_done = 1'b0;

   function automatic color_type cast_vote(int ch, reading_type rd, zone_level_type lvl);
      int        z;
      color_type hue;
      if (rd >= lvl.danger) begin
         z = ZONE_DANGER;
         hue = COLOR_RED;
      end else if (rd >= lvl.warn) begin
         z = ZONE_WARN;
         hue = COLOR_ORANGE;
      end else begin
         z = ZONE_NORMAL;
         hue = COLOR_GREEN;
      end
      for (int k = 0; k < 3; k++)
         if (k != z && zone_tally[ch][k] != '0)
            zone_tally[ch][k] = zone_tally[ch][k] - CNT_W'(1);
      if (zone_tally[ch][z] != CNT_MAX) zone_tally[ch][z] = zone_tally[ch][z] + CNT_W'(1);
      if (zone_tally[ch][z] >= VOTE_LIMIT) begin
         zone_tally[ch][z] = '0;
         return hue;
      end
      return COLOR_NONE;
   endfunction

   function automatic buzz_type buzz_after(color_type hue, logic snd, buzz_type act);
      if (hue == COLOR_NONE) return act;
      if (hue == COLOR_RED && snd) begin
         if (alarm_armed) begin
            alarm_armed = 1'b0;
            return BUZZ_START;
         end
         return act;
      end
      alarm_armed = 1'b1;
      return BUZZ_STOP;
   endfunction

   function automatic led_report_type vote_round(meas_round_type r);
      led_report_type rep;
      color_type      a, b, c;
      rep.co2 = COLOR_NONE;
      rep.tvoc = COLOR_NONE;
      rep.pm = COLOR_NONE;
      rep.buzz = BUZZ_NONE;
      if (r.cmd == CMD_GAS) begin
         rep.co2 = cast_vote(CH_CO2, r.co2, zone_levels.co2);
         rep.buzz = buzz_after(rep.co2, r.snd, rep.buzz);
         rep.tvoc = cast_vote(CH_TVOC, r.tvoc, zone_levels.tvoc);
         rep.buzz = buzz_after(rep.tvoc, r.snd, rep.buzz);
      end else begin
         a = cast_vote(CH_PM1, r.pm1, zone_levels.fine_pm);
         b = cast_vote(CH_PM25, r.pm25, zone_levels.fine_pm);
         c = cast_vote(CH_PM10, r.pm10, zone_levels.coarse_pm);
         if (a == COLOR_RED || b == COLOR_RED || c == COLOR_RED)
            rep.pm = COLOR_RED;
         else if (a == COLOR_ORANGE || b == COLOR_ORANGE || c == COLOR_ORANGE)
            rep.pm = COLOR_ORANGE;
         else if (a == COLOR_GREEN || b == COLOR_GREEN || c == COLOR_GREEN)
            rep.pm = COLOR_GREEN;
         rep.buzz = buzz_after(rep.pm, r.snd, rep.buzz);
      end
      return rep;
   endfunction

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic void queue_round(logic cmd, reading_type co2, reading_type tvoc,
                                       reading_type pm1, reading_type pm25, reading_type pm10,
                                       logic snd, bit drain);
      meas_round_type r;
      r.cmd = cmd;
      r.co2 = co2;
      r.tvoc = tvoc;
      r.pm1 = pm1;
      r.pm25 = pm25;
      r.pm10 = pm10;
      r.snd = snd;
      r.drain_first = drain;
      pending_rounds.push_back(r);
   endfunction

   // Keep each channel in one zone for a short run so the tallies can reach the limit.
   function automatic reading_type next_reading(int ch);
      zone_level_type lvl;
      reading_type    lo, hi;
      case (ch)
         CH_CO2:  lvl = zone_levels.co2;
         CH_TVOC: lvl = zone_levels.tvoc;
         CH_PM10: lvl = zone_levels.coarse_pm;
         default: lvl = zone_levels.fine_pm;
      endcase
      if (run_left[ch] == 0) begin
         run_zone[ch] = $urandom_range(ZONE_NORMAL, ZONE_DANGER);
         run_left[ch] = $urandom_range(1, 6);
      end
      run_left[ch]--;
      if ($urandom_range(0, 9) == 0) return reading_type'($urandom);
      lo = '0;
      hi = '1;
      case (run_zone[ch])
         ZONE_DANGER: lo = lvl.danger;
         ZONE_WARN: begin
            if (lvl.warn < lvl.danger) begin
               lo = lvl.warn;
               hi = lvl.danger - reading_type'(1);
            end
         end
         default: begin
            if (lvl.warn != '0 && lvl.danger != '0)
               hi = ((lvl.warn < lvl.danger) ? lvl.warn : lvl.danger) - reading_type'(1);
         end
      endcase
      if ($urandom_range(0, 4) == 0) return lo;
      if ($urandom_range(0, 4) == 0) return hi;
      return reading_type'($urandom_range(hi, lo));
   endfunction

   task automatic write_level(csr_idx_type idx, reading_type val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_CO2_WARN:         zone_levels.co2.warn = val;
         REG_CO2_DANGER:       zone_levels.co2.danger = val;
         REG_TVOC_WARN:        zone_levels.tvoc.warn = val;
         REG_TVOC_DANGER:      zone_levels.tvoc.danger = val;
         REG_FINE_PM_WARN:     zone_levels.fine_pm.warn = val;
         REG_FINE_PM_DANGER:   zone_levels.fine_pm.danger = val;
         REG_COARSE_PM_WARN:   zone_levels.coarse_pm.warn = val;
         REG_COARSE_PM_DANGER: zone_levels.coarse_pm.danger = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic program_levels(int setting);
      zone_level_type grp [4];
      for (int g = 0; g < 4; g++) begin
         case (setting)
            LV_CROSSED: begin
               grp[g].danger = reading_type'($urandom_range(0, 40000));
               grp[g].warn = reading_type'($urandom_range(grp[g].danger, 16'hFFFF));
            end
            LV_WIDE: grp[g] = '{warn: 16'h0000, danger: 16'hFFFF};
            LV_TOP:  grp[g] = '{warn: 16'hFFFF, danger: 16'hFFFF};
            LV_RANDOM: begin
               grp[g].warn = reading_type'($urandom_range(0, 60000));
               grp[g].danger = reading_type'($urandom_range(grp[g].warn, 16'hFFFF));
            end
            default: ;
         endcase
      end
      if (setting == LV_TYPICAL) begin
         grp[0] = '{warn: 16'd1000, danger: 16'd2000};
         grp[1] = '{warn: 16'd220, danger: 16'd660};
         grp[2] = '{warn: 16'd35, danger: 16'd75};
         grp[3] = '{warn: 16'd50, danger: 16'd150};
      end
      // equal levels on the fine channels: warning zone is empty
      if (setting == LV_CROSSED) grp[2] = '{warn: 16'd500, danger: 16'd500};
      write_level(REG_CO2_WARN, grp[0].warn);
      write_level(REG_CO2_DANGER, grp[0].danger);
      write_level(REG_TVOC_WARN, grp[1].warn);
      write_level(REG_TVOC_DANGER, grp[1].danger);
      write_level(REG_FINE_PM_WARN, grp[2].warn);
      write_level(REG_FINE_PM_DANGER, grp[2].danger);
      write_level(REG_COARSE_PM_WARN, grp[3].warn);
      write_level(REG_COARSE_PM_DANGER, grp[3].danger);
      // out-of-range index must be dropped
      write_level(csr_idx_type'($urandom_range(REG_COARSE_PM_DANGER + 1, {CSR_IDX_W{1'b1}})),
                  reading_type'($urandom));
      level_sets++;
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_rounds.size() != 0 || req_valid || expected_reports.size() != 0);
   endtask

   task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 128 == 0) no_idle <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin : round_driver
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_reports.push_back(vote_round(shown_round));
            accepted_rounds++;
            if (shown_round.cmd == CMD_GAS) gas_rounds++;
            else pm_rounds++;
         end
         // hold a stalled item as it is
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_rounds.size() != 0 &&
                         !(pending_rounds[0].drain_first && expected_reports.size() != 0)) begin
               shown_round = pending_rounds.pop_front();
               req_command <= shown_round.cmd;
               req_co2_reading <= shown_round.co2;
               req_tvoc_reading <= shown_round.tvoc;
               req_pm1_reading <= shown_round.pm1;
               req_pm25_reading <= shown_round.pm25;
               req_pm10_reading <= shown_round.pm10;
               req_sound_enabled <= shown_round.snd;
               req_valid <= 1'b1;
               gap_left = (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_span();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_backpressure
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!long_hold_done && accepted_rounds >= LONG_HOLD_AT) begin
         // hold off long enough for the block to fill and stall its input
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (no_idle || $urandom_range(0, 99) < 75) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left = idle_span() - 1;
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin : report_check
      led_report_type want;
      color_type      hues [3];
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("result item with no expectation pending");
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("co2_color", want.co2, rsp_co2_color);
            check_field("tvoc_color", want.tvoc, rsp_tvoc_color);
            check_field("pm_color", want.pm, rsp_pm_color);
            check_field("buzzer_action", want.buzz, rsp_buzzer_action);
         end
         hues = '{rsp_co2_color, rsp_tvoc_color, rsp_pm_color};
         foreach (hues[k]) begin
            if (hues[k] == COLOR_RED) red_seen++;
            if (hues[k] == COLOR_ORANGE) orange_seen++;
            if (hues[k] == COLOR_GREEN) green_seen++;
         end
         if (rsp_buzzer_action == BUZZ_START) starts_seen++;
         if (rsp_buzzer_action == BUZZ_STOP) stops_seen++;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("FAIL air_quality_zone_voter_unit");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int hold_at;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // levels still at reset: every reading is in the danger zone
      repeat (3) queue_round(CMD_GAS, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      repeat (3) queue_round(CMD_GAS, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
      repeat (3) queue_round(CMD_PM, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
      wait_quiet();

      program_levels(LV_TYPICAL);
      // readings exactly on and just below the levels; unused readings at extremes
      repeat (3) queue_round(CMD_GAS, 16'd2000, 16'd219, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      repeat (3) queue_round(CMD_GAS, 16'd1000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
      repeat (3) queue_round(CMD_GAS, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
      repeat (3) queue_round(CMD_PM, 16'hFFFF, 16'h0000, 16'd0, 16'd75, 16'd150, 1'b1, 1'b0);
      repeat (3) queue_round(CMD_PM, 16'h0000, 16'hFFFF, 16'd35, 16'd34, 16'd49, 1'b0, 1'b0);
      queue_round(CMD_PM, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      wait_quiet();

      for (int s = LV_TYPICAL; s <= LV_RANDOM; s++) begin
         program_levels(s);
         hold_at = $urandom_range(50, 300);
         for (int i = 0; i < ROUNDS_PER_SET; i++)
            queue_round(logic'($urandom_range(0, 1)),
                        next_reading(CH_CO2), next_reading(CH_TVOC), next_reading(CH_PM1),
                        next_reading(CH_PM25), next_reading(CH_PM10),
                        logic'($urandom_range(0, 9) < 7), i == hold_at);
         wait_quiet();
      end

      repeat (10) @(posedge clock);
      if (expected_reports.size() != 0) begin
         $error("%0d expected result items never arrived", expected_reports.size());
         mismatch_count++;
      end
      $display("Covered %0d gas and %0d particulate rounds under %0d level sets",
               gas_rounds, pm_rounds, level_sets);
      $display("Colors reported: %0d red, %0d orange, %0d green; buzzer %0d starts, %0d stops",
               red_seen, orange_seen, green_seen, starts_seen, stops_seen);
      if (mismatch_count == 0) begin
         $display("PASS air_quality_zone_voter_unit");
      end else begin
         $display("FAIL air_quality_zone_voter_unit");
      end
      $finish;
   end

endmodule
